// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never be true while out of reset
`define ASSERT_NEVER(lbl, ck, rn, cond) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
        else $error("check failed: never");

// ante implies cons in the following cycle
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("check failed: next");

`endif

// ===== rtl/egn_pkg.sv =====
// Types and constants for the exponential gain block.
// No dependencies.
package egn_pkg;

    localparam int ELEM_W     = 16;
    localparam int SUM_W      = 37;
    localparam int NORM_W     = 19;
    localparam int GAIN_W     = 20;
    localparam int RATE_W     = 24;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_ADDR_W-1:0] REG_SPAN  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RATE  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FLOOR = 2'd2;

    localparam logic [GAIN_W-1:0] FLOOR_RESET = 20'd6554;   // 0.1 in Q4.16

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // exponent bounds in Q30
    localparam logic signed [45:0] Y_LOW  = -46'sd34359738368;  // -32
    localparam logic signed [45:0] Y_HIGH = 46'sd17179869184;   // 16

    localparam logic [36:0]        LN2_Q30  = 37'd744261118;
    localparam logic signed [45:0] RED_BIAS = 46'sd34980272546; // 47 * ln2
    localparam logic signed [6:0]  K_START  = -7'sd47;
    localparam logic [31:0]        ONE_Q30  = 32'd1073741824;
    localparam logic [3:0]         TAYLOR_N = 4'd13;

    localparam logic signed [47:0] GAIN_HI = 48'sd524287;
    localparam logic signed [47:0] GAIN_LO = -48'sd524288;

    typedef struct packed {
        logic signed [GAIN_W-1:0] span;
        logic signed [RATE_W-1:0] rate;
        logic signed [GAIN_W-1:0] gfloor;
    } coef_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain;
        logic                     sat;
    } res_t;

endpackage

// ===== rtl/egn_fifo.sv =====
// Small register queue used between front and back and at the result side.
// Depends on nothing.
module egn_fifo #(
    parameter int WIDTH = 37,
    parameter int DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wp_reg, wp_next, rp_reg, rp_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign do_push = push && (cnt_reg < CW'(DEPTH));
    assign do_pop  = pop && (cnt_reg != '0);
    assign rdata   = mem_reg[rp_reg];
    assign count   = cnt_reg;

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wp_next = (wp_reg == PW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
        end
        if (do_pop)
        begin
            rp_next = (rp_reg == PW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/egn_front.sv =====
// Front end: squares elements, sums the first MAX_ELEMENTS squares of a vector.
// Depends on egn_pkg.
module egn_front #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic signed [15:0]          error_element,
    input  logic                        last_element,
    input  logic [1:0]                  q_count,
    output logic                        q_push,
    output logic [36:0]                 q_data
);
    import egn_pkg::*;

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    logic             accept;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_last_reg, s1_use_reg;
    logic [31:0]      s1_sq_reg;
    logic [SUM_W-1:0] sum_reg, sum_next, sum_add;
    logic [SUM_W:0]   sum_wide;
    logic             use_now;

    // one vector may still be finishing in the square stage
    assign full   = (q_count == 2'd2) || (q_count == 2'd1 && s1_valid_reg && s1_last_reg);
    assign accept = push && !full;
    assign use_now = cnt_reg < CNT_W'(MAX_ELEMENTS);

    assign sum_wide = {1'b0, sum_reg} + {6'd0, s1_sq_reg};
    assign sum_add  = !s1_use_reg ? sum_reg : (sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0]);

    assign q_push = s1_valid_reg && s1_last_reg;
    assign q_data = sum_add;

    always_comb
    begin
        cnt_next      = cnt_reg;
        s1_valid_next = accept;
        sum_next      = sum_reg;
        if (accept)
        begin
            if (last_element)
            begin
                cnt_next = '0;
            end
            else if (use_now)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        if (s1_valid_reg)
        begin
            sum_next = s1_last_reg ? '0 : sum_add;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            s1_valid_reg <= 1'b0;
            sum_reg      <= '0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            s1_valid_reg <= s1_valid_next;
            sum_reg      <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sq_reg   <= 32'(32'(error_element) * 32'(error_element));
            s1_last_reg <= last_element;
            s1_use_reg  <= use_now;
        end
    end

endmodule

// ===== rtl/egn_back.sv =====
// Back end: square root, exponent range reduction, Taylor series and scaling.
// Depends on egn_pkg.
module egn_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  egn_pkg::coef_t        coef,
    input  logic                  in_valid,
    input  logic [36:0]           in_sum,
    output logic                  in_pop,
    input  logic                  out_full,
    output logic                  out_push,
    output egn_pkg::res_t         out_res
);
    import egn_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQRT  = 4'd1;
    localparam logic [3:0] S_MULB  = 4'd2;
    localparam logic [3:0] S_CHECK = 4'd3;
    localparam logic [3:0] S_RED   = 4'd4;
    localparam logic [3:0] S_TMUL  = 4'd5;
    localparam logic [3:0] S_TDIV  = 4'd6;
    localparam logic [3:0] S_MAG   = 4'd7;
    localparam logic [3:0] S_SHIFT = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;
    localparam logic [3:0] S_EMIT  = 4'd10;
    localparam logic [3:0] S_TFIX  = 4'd11;

    // floor(2^32 / d) for the Taylor divisors 1 .. 13
    function automatic logic [32:0] recip_q32(input logic [3:0] d);
        logic [32:0] m;
        unique case (d)
            4'd1:    m = 33'd4294967296;
            4'd2:    m = 33'd2147483648;
            4'd3:    m = 33'd1431655765;
            4'd4:    m = 33'd1073741824;
            4'd5:    m = 33'd858993459;
            4'd6:    m = 33'd715827882;
            4'd7:    m = 33'd613566756;
            4'd8:    m = 33'd536870912;
            4'd9:    m = 33'd477218588;
            4'd10:   m = 33'd429496729;
            4'd11:   m = 33'd390451572;
            4'd12:   m = 33'd357913941;
            4'd13:   m = 33'd330382099;
            default: m = '0;
        endcase
        return m;
    endfunction

    logic [3:0]          state_reg, state_next;
    logic [36:0]         v_reg, v_next, bit_reg, bit_next;
    logic [37:0]         root_reg, root_next, trial;
    logic [4:0]          cnt_reg, cnt_next;
    logic signed [43:0]  prod_reg, prod_next;
    logic signed [45:0]  y;
    logic [45:0]         red_sum;
    logic [36:0]         racc_reg, racc_next;
    logic signed [6:0]   k_reg, k_next;
    logic [29:0]         r_reg, r_next;
    logic [30:0]         term_reg, term_next, dvd_reg, dvd_next;
    logic [30:0]         qe_reg, qe_next, tq;
    logic [31:0]         sum_reg, sum_next;
    logic [3:0]          n_reg, n_next;
    logic [63:0]         dprod;
    logic [34:0]         qn;
    logic [60:0]         tprod;
    logic [51:0]         mag_reg, mag_next;
    logic [45:0]         q_reg, q_next;
    logic [7:0]          s;
    logic [63:0]         rnd;
    logic signed [47:0]  qs, g;
    logic [19:0]         abs_a;
    res_t                res_reg, res_next;

    assign trial   = root_reg + {1'b0, bit_reg};
    assign y       = -(46'(prod_reg) <<< 2);
    assign red_sum = 46'(y + RED_BIAS);
    assign tprod   = 61'(term_reg) * 61'(r_reg);
    // reciprocal estimate is the quotient or one below it; one compare fixes it
    assign dprod   = 64'(dvd_reg) * 64'(recip_q32(n_reg));
    assign qn      = 35'(qe_reg) * 35'(n_reg);
    assign tq      = (35'(dvd_reg) - qn >= 35'(n_reg)) ? qe_reg + 31'd1 : qe_reg;
    assign abs_a   = coef.span[19] ? 20'(-coef.span) : coef.span;
    assign s       = 8'd30 - 8'(k_reg);
    assign rnd     = 64'(mag_reg) + (64'd1 << (s - 8'd1));
    assign qs      = $signed(48'({2'b00, q_reg}));
    assign g       = 48'(coef.gfloor) + (coef.span[19] ? -qs : qs);

    assign in_pop   = (state_reg == S_IDLE) && in_valid;
    assign out_push = (state_reg == S_EMIT) && !out_full;
    assign out_res  = res_reg;

    always_comb
    begin
        state_next = state_reg;
        v_next     = v_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        racc_next  = racc_reg;
        k_next     = k_reg;
        r_next     = r_reg;
        term_next  = term_reg;
        dvd_next   = dvd_reg;
        qe_next    = qe_reg;
        sum_next   = sum_reg;
        n_next     = n_reg;
        mag_next   = mag_reg;
        q_next     = q_reg;
        res_next   = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    v_next     = in_sum;
                    root_next  = '0;
                    bit_next   = 37'd1 << 36;
                    cnt_next   = 5'd18;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if ({1'b0, v_reg} >= trial)
                begin
                    v_next    = 37'({1'b0, v_reg} - trial);
                    root_next = (root_reg >> 1) + {1'b0, bit_reg};
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_MULB;
                end
            end
            S_MULB:
            begin
                prod_next  = 44'(coef.rate) * 44'($signed({1'b0, root_reg[NORM_W-1:0]}));
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (coef.span == '0 || y < Y_LOW)
                begin
                    res_next   = '{gain: coef.gfloor, sat: 1'b0};
                    state_next = S_EMIT;
                end
                else if (y > Y_HIGH)
                begin
                    res_next.gain = coef.span[19] ? 20'sh80000 : 20'sh7FFFF;
                    res_next.sat  = 1'b1;
                    state_next    = S_EMIT;
                end
                else
                begin
                    racc_next  = red_sum[36:0];
                    k_next     = K_START;
                    state_next = S_RED;
                end
            end
            S_RED:
            begin
                // one ln2 step per cycle until the remainder is below ln2
                if (racc_reg >= LN2_Q30)
                begin
                    racc_next = racc_reg - LN2_Q30;
                    k_next    = k_reg + 7'sd1;
                end
                else
                begin
                    r_next     = racc_reg[29:0];
                    sum_next   = ONE_Q30;
                    term_next  = 31'(ONE_Q30);
                    n_next     = 4'd1;
                    state_next = S_TMUL;
                end
            end
            S_TMUL:
            begin
                dvd_next   = tprod[60:30];
                state_next = S_TDIV;
            end
            S_TDIV:
            begin
                qe_next    = dprod[62:32];
                state_next = S_TFIX;
            end
            S_TFIX:
            begin
                term_next = tq;
                sum_next  = sum_reg + {1'b0, tq};
                if (n_reg == TAYLOR_N)
                begin
                    state_next = S_MAG;
                end
                else
                begin
                    n_next     = n_reg + 1'b1;
                    state_next = S_TMUL;
                end
            end
            S_MAG:
            begin
                mag_next   = 52'(abs_a) * 52'(sum_reg);
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                q_next     = (s >= 8'd63) ? '0 : 46'(rnd >> s);
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (g > GAIN_HI)
                begin
                    res_next = '{gain: 20'sh7FFFF, sat: 1'b1};
                end
                else if (g < GAIN_LO)
                begin
                    res_next = '{gain: 20'sh80000, sat: 1'b1};
                end
                else
                begin
                    res_next = '{gain: g[19:0], sat: 1'b0};
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_full)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            n_reg     <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        prod_reg <= prod_next;
        racc_reg <= racc_next;
        k_reg    <= k_next;
        r_reg    <= r_next;
        term_reg <= term_next;
        dvd_reg  <= dvd_next;
        qe_reg   <= qe_next;
        sum_reg  <= sum_next;
        mag_reg  <= mag_next;
        q_reg    <= q_next;
        res_reg  <= res_next;
    end

endmodule

// ===== rtl/exponential_gain_from_error_norm.sv =====
// Top level of the exponential gain block: config registers, front, queues, back.
// Depends on egn_pkg, egn_front, egn_fifo, egn_back and assert_macros.svh.
//
// Usage: error elements (signed Q4.12) are pushed one per beat on push/full,
// last_element closing a vector. Each closed vector yields one result beat
// (gain, saturated) read from the result queue with empty/pop.
// The front accepts one element per cycle while full is low, squaring it in a
// registered stage. The back end works through one vector at a time: it takes
// the sum, computes the square root bit by bit, forms the exponent (multiply,
// range check), reduces it by ln2 steps, sums 13 Taylor terms (multiply,
// reciprocal estimate, correction), scales (magnitude, shift, floor and clamp)
// and hands the result over. Zero span and an exponent out of range go straight
// to the hand-over. It takes a new vector only when idle, which sets the vector rate.
// Two closed vectors can wait between front and back, two results at the
// output; while the consumer stalls the back holds its result and the queues
// fill, then full rises. Reset empties everything, clears the sum and loads
// the coefficient registers (span 0, rate 0, floor 0.1).
// Coefficients are written through cfg_we/cfg_addr/cfg_wdata with no wait.
module exponential_gain_from_error_norm #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic signed [15:0]                 error_element,
    input  logic                               last_element,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [19:0]                 gain,
    output logic                               saturated,
    input  logic                               cfg_we,
    input  logic [egn_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [egn_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import egn_pkg::*;
`include "assert_macros.svh"

    coef_t       coef_reg, coef_next;
    logic        mid_push, mid_pop;
    logic [36:0] mid_wdata, mid_rdata;
    logic [1:0]  mid_count, out_count;
    logic        out_push, out_pop;
    res_t        out_wres, out_rres;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_SPAN:  coef_next.span   = cfg_wdata[19:0];
                REG_RATE:  coef_next.rate   = cfg_wdata;
                REG_FLOOR: coef_next.gfloor = cfg_wdata[19:0];
                default:   coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '{span: '0, rate: '0, gfloor: FLOOR_RESET};
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    egn_front #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .error_element (error_element),
        .last_element  (last_element),
        .q_count       (mid_count),
        .q_push        (mid_push),
        .q_data        (mid_wdata)
    );

    egn_fifo #(.WIDTH(37), .DEPTH(2)) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_wdata),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .count (mid_count)
    );

    egn_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .coef     (coef_reg),
        .in_valid (mid_count != 2'd0),
        .in_sum   (mid_rdata),
        .in_pop   (mid_pop),
        .out_full (out_count == 2'd2),
        .out_push (out_push),
        .out_res  (out_wres)
    );

    egn_fifo #(.WIDTH($bits(res_t)), .DEPTH(2)) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_wres),
        .pop   (out_pop),
        .rdata (out_rres),
        .count (out_count)
    );

    assign empty     = (out_count == 2'd0);
    assign out_pop   = pop && !empty;
    assign gain      = out_rres.gain;
    assign saturated = out_rres.sat;

    `ASSERT_NEVER(a_mid_overflow, clk, rst_n, mid_push && mid_count == 2'd2)
    `ASSERT_NEVER(a_out_overflow, clk, rst_n, out_push && out_count == 2'd2)
    `ASSERT_NEXT(a_last_drain, clk, rst_n, out_pop && out_count == 2'd1 && !out_push, empty)

endmodule
